[hdl/pfge_pkg.sv]
package pfge_pkg;

  // Stack geometry
  localparam int unsigned MAX_PANCAKES = 16;
  localparam int unsigned MIN_PANCAKES = 2;
  localparam int unsigned LANE_W       = 4;
  localparam int unsigned STACK_W      = MAX_PANCAKES * LANE_W;
  localparam int unsigned CNT_W        = $clog2(MAX_PANCAKES + 1);
  localparam int unsigned IDX_W        = $clog2(MAX_PANCAKES);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = STACK_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PANCAKE_COUNT  = 1'b0,
    CFG_GOAL_POSITIONS = 1'b1
  } cfg_idx_e;

  // Opcodes
  localparam logic OP_EVAL = 1'b0;
  localparam logic OP_FLIP = 1'b1;

  // Reset values: full stack, pancake v belongs at position v
  localparam logic [CNT_W-1:0]   COUNT_RST = CNT_W'(MAX_PANCAKES);
  localparam logic [STACK_W-1:0] GOAL_RST  = 64'hFEDC_BA98_7654_3210;

  typedef struct packed {
    logic               opcode;
    logic [STACK_W-1:0] stack;
    logic [CNT_W-1:0]   flip_size;
  } in_t;

  typedef struct packed {
    logic [STACK_W-1:0] new_stack;
    logic [CNT_W-1:0]   gap_count;
    logic               at_goal;
    logic               bad_flip;
  } out_t;

endpackage

[hdl/pancake_flip_gap_evaluator_unit.sv]
// Pancake prefix-reversal gap evaluator. Each item carries a packed stack
// (4 bits per position, top in the low bits), an opcode and a flip size;
// opcode 1 reverses the top flip_size positions before evaluation. The
// result holds the new stack, the gap count under the configured goal
// table, an at-goal flag and a bad-flip flag (flip larger than the pancake
// count; stack then left as is). The block takes one item every clock
// unless the input stalls, and passes it through one input register,
// one evaluation pass of lane muxes and a popcount, one result register.
// Input stall only rises while both registers are full and the result side
// stalls. Configuration (pancake_count, goal_positions) must be written through
// cfg_we_i/cfg_idx_i/cfg_data_i while the block is idle; nothing enforces it.
module pancake_flip_gap_evaluator_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Config write port
  input  logic                                cfg_we_i,
  input  logic [pfge_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pfge_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  pfge_pkg::in_t                       in_data_i,
  // Result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output pfge_pkg::out_t                      out_data_o
);

  logic [pfge_pkg::CNT_W-1:0]   eff_cnt_q, eff_cnt_d;
  logic [pfge_pkg::STACK_W-1:0] goal_pos_q, goal_pos_d;
  logic [pfge_pkg::CNT_W-1:0]   cfg_cnt;

  logic           s1_valid_q, s1_valid_d;
  pfge_pkg::in_t  s1_q;
  logic           out_valid_q, out_valid_d;
  pfge_pkg::out_t out_q;
  pfge_pkg::out_t eval_out;
  logic           out_adv;
  logic           in_acc;

  // Config decode; pancake count is clamped on write
  always_comb begin
    eff_cnt_d  = eff_cnt_q;
    goal_pos_d = goal_pos_q;
    cfg_cnt    = cfg_data_i[pfge_pkg::CNT_W-1:0];
    if (cfg_we_i) begin
      unique case (pfge_pkg::cfg_idx_e'(cfg_idx_i))
        pfge_pkg::CFG_PANCAKE_COUNT: begin
          if (cfg_cnt < pfge_pkg::CNT_W'(pfge_pkg::MIN_PANCAKES)) begin
            eff_cnt_d = pfge_pkg::CNT_W'(pfge_pkg::MIN_PANCAKES);
          end else if (cfg_cnt > pfge_pkg::CNT_W'(pfge_pkg::MAX_PANCAKES)) begin
            eff_cnt_d = pfge_pkg::CNT_W'(pfge_pkg::MAX_PANCAKES);
          end else begin
            eff_cnt_d = cfg_cnt;
          end
        end
        pfge_pkg::CFG_GOAL_POSITIONS: goal_pos_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_cnt_q  <= pfge_pkg::COUNT_RST;
      goal_pos_q <= pfge_pkg::GOAL_RST;
    end else begin
      eff_cnt_q  <= eff_cnt_d;
      goal_pos_q <= goal_pos_d;
    end
  end

  // Two-stage flow control
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (out_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_adv ? s1_valid_q : 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_data_i;
    end
    if (out_adv && s1_valid_q) begin
      out_q <= eval_out;
    end
  end

  pfge_eval u_eval (
    .item_i     (s1_q),
    .eff_cnt_i  (eff_cnt_q),
    .goal_pos_i (goal_pos_q),
    .result_o   (eval_out)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // Item in the input register moves to the result register when it frees
  a_s1_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_adv |=> out_valid_q)
    else $error("input register item not moved to result register");

  // Input only stalls with both stages full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with a free stage");

  // A stack at its goal has no gaps
  a_goal_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.at_goal |-> out_q.gap_count == '0)
    else $error("at_goal with nonzero gap count");

  // A rejected flip leaves the stack untouched
  a_bad_unflipped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && eval_out.bad_flip |-> eval_out.new_stack == s1_q.stack)
    else $error("bad flip changed the stack");

  // Effective pancake count stays in range
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> eff_cnt_q >= pfge_pkg::CNT_W'(pfge_pkg::MIN_PANCAKES)
                 && eff_cnt_q <= pfge_pkg::CNT_W'(pfge_pkg::MAX_PANCAKES))
    else $error("pancake count out of range");
`endif

endmodule

[hdl/pfge_eval.sv]
module pfge_eval (
  input  pfge_pkg::in_t                    item_i,
  input  logic [pfge_pkg::CNT_W-1:0]       eff_cnt_i,
  input  logic [pfge_pkg::STACK_W-1:0]     goal_pos_i,
  output pfge_pkg::out_t                   result_o
);

  logic [pfge_pkg::LANE_W-1:0] in_lane   [pfge_pkg::MAX_PANCAKES];
  logic [pfge_pkg::LANE_W-1:0] goal_lut  [pfge_pkg::MAX_PANCAKES];
  logic [pfge_pkg::LANE_W-1:0] new_lane  [pfge_pkg::MAX_PANCAKES];
  logic [pfge_pkg::LANE_W-1:0] lane_goal [pfge_pkg::MAX_PANCAKES];
  logic [pfge_pkg::MAX_PANCAKES-2:0] gap_bits;
  logic [pfge_pkg::MAX_PANCAKES-1:0] mis_bits;
  logic [pfge_pkg::MAX_PANCAKES-1:0] used_mis;
  logic [pfge_pkg::IDX_W-1:0]        last_idx;
  logic [pfge_pkg::IDX_W-1:0]        src_idx;
  logic [pfge_pkg::LANE_W-1:0]       diff;
  logic                              bad;
  logic                              do_flip;
  logic                              bottom_gap;

  always_comb begin
    // Unpack stack and goal table into lanes
    for (int p = 0; p < pfge_pkg::MAX_PANCAKES; p++) begin
      in_lane[p]  = item_i.stack[p*pfge_pkg::LANE_W +: pfge_pkg::LANE_W];
      goal_lut[p] = goal_pos_i[p*pfge_pkg::LANE_W +: pfge_pkg::LANE_W];
    end

    // Oversized flip leaves the stack alone
    bad      = (item_i.opcode == pfge_pkg::OP_FLIP) && (item_i.flip_size > eff_cnt_i);
    do_flip  = (item_i.opcode == pfge_pkg::OP_FLIP) && !bad;
    last_idx = pfge_pkg::IDX_W'(eff_cnt_i - pfge_pkg::CNT_W'(1));

    // Prefix reversal: lane p below flip_size takes lane flip_size-1-p
    for (int p = 0; p < pfge_pkg::MAX_PANCAKES; p++) begin
      src_idx = pfge_pkg::IDX_W'(item_i.flip_size - pfge_pkg::CNT_W'(1)
                                 - pfge_pkg::CNT_W'(p));
      if (do_flip && (pfge_pkg::CNT_W'(p) < item_i.flip_size)) begin
        new_lane[p] = in_lane[src_idx];
      end else begin
        new_lane[p] = in_lane[p];
      end
      lane_goal[p] = goal_lut[new_lane[p]];
      mis_bits[p]  = (lane_goal[p] != pfge_pkg::LANE_W'(p));
      used_mis[p]  = mis_bits[p] && (pfge_pkg::CNT_W'(p) < eff_cnt_i);
    end

    // Adjacent pairs whose goals differ by more than one
    for (int p = 0; p < pfge_pkg::MAX_PANCAKES - 1; p++) begin
      diff = (lane_goal[p] > lane_goal[p+1]) ? (lane_goal[p] - lane_goal[p+1])
                                             : (lane_goal[p+1] - lane_goal[p]);
      gap_bits[p] = (diff > pfge_pkg::LANE_W'(1))
                    && (pfge_pkg::CNT_W'(p + 1) < eff_cnt_i);
    end

    // Bottom pancake out of place counts as one more gap
    bottom_gap = mis_bits[last_idx];

    for (int p = 0; p < pfge_pkg::MAX_PANCAKES; p++) begin
      result_o.new_stack[p*pfge_pkg::LANE_W +: pfge_pkg::LANE_W] = new_lane[p];
    end
    result_o.gap_count = pfge_pkg::CNT_W'($countones(gap_bits))
                         + pfge_pkg::CNT_W'(bottom_gap);
    result_o.at_goal   = (used_mis == '0);
    result_o.bad_flip  = bad;
  end

endmodule
